### rtl/core/dra_pkg.sv
// Shared types, codes and defaults for the delayed-recycle ID allocator.
package dra_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int COUNT_BITS_DEF    = 16;

	// IDs 0 and 1..RESERVED_LAST are never handed out fresh
	localparam logic [31:0] RESERVED_LAST = 32'd1;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_DROP   = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_RECYCLED = 2'd1;
	localparam logic [1:0] STS_DUP      = 2'd2;
	localparam logic [1:0] STS_FULL     = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_C_FIFO,
		S_C_TBL,
		S_SCAN,
		S_SCAN_END,
		S_DECIDE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic attr_we;
		logic alloc;
	} tbl_ctl_t;

endpackage

### rtl/core/dra_if.sv
// Request and response channel interfaces of the ID allocator.
interface dra_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] now_ticks;
	logic [31:0] target_id;

	modport source (output valid, output opcode, output now_ticks, output target_id,
		input ready);
	modport sink (input valid, input opcode, input now_ticks, input target_id,
		output ready);
endinterface

interface dra_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_id;
	logic [15:0] reuse_count;
	logic [1:0]  status;

	modport source (output valid, output result_id, output reuse_count, output status,
		input ready);
	modport sink (input valid, input result_id, input reuse_count, input status,
		output ready);
endinterface

### rtl/core/dra_fifo.sv
// Quarantine queue of table indexes, kept in a memory with head, tail and count.
module dra_fifo import dra_pkg::*; #(
	parameter int DEPTH = TABLE_ENTRIES_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fifo_ctl_t        ctl,
	input  logic [IDX_W-1:0] push_idx,
	output logic [IDX_W-1:0] head_idx_q,
	output logic             empty
);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [IDX_W-1:0] mem [DEPTH];
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = ctl.push && !full;
	assign do_pop  = ctl.pop && !empty;

	// Write the tail slot, read the head slot every cycle
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail_q] <= push_idx;
		end
		head_idx_q <= mem[head_q];
	end

	// Advance pointers with wrap and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (do_pop) begin
				head_q <= (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/dra_table.sv
// Table of dropped IDs: ID memory, attribute memory and a fill count.
module dra_table import dra_pkg::*; #(
	parameter int N      = TABLE_ENTRIES_DEF,
	parameter int CB     = COUNT_BITS_DEF,
	parameter int IDX_W  = $clog2(N),
	parameter int USED_W = $clog2(N + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [31:0]       rd_id_q,
	output logic              rd_dropped_q,
	output logic [31:0]       rd_time_q,
	output logic [CB-1:0]     rd_cnt_q,
	input  tbl_ctl_t          ctl,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [31:0]       wr_id,
	input  logic              wr_dropped,
	input  logic [31:0]       wr_time,
	input  logic [CB-1:0]     wr_cnt,
	output logic [USED_W-1:0] used_q,
	output logic              full
);
	localparam int AW = 1 + 32 + CB;

	logic [31:0]   id_mem   [N];
	logic [AW-1:0] attr_mem [N];
	logic [AW-1:0] attr_rd;

	assign full = (used_q == USED_W'(N));
	assign {rd_dropped_q, rd_time_q, rd_cnt_q} = attr_rd;

	// Write on allocation or attribute update, read one row every cycle
	always_ff @(posedge clk) begin
		if (ctl.alloc) begin
			id_mem[wr_addr] <= wr_id;
		end
		if (ctl.attr_we) begin
			attr_mem[wr_addr] <= {wr_dropped, wr_time, wr_cnt};
		end
		rd_id_q <= id_mem[rd_addr];
		attr_rd <= attr_mem[rd_addr];
	end

	// Rows fill in order and are never freed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (ctl.alloc && !full) begin
			used_q <= used_q + 1'b1;
		end
	end

endmodule

### rtl/core/delayed_recycle_id_allocator.sv
// Delayed-recycle ID allocator: sequencer, shared ID compare and result register.
// Create takes a fresh ID when the quarantine queue is empty, else checks the queue head age first;
// drop and query scan one table row per cycle over all TABLE_ENTRIES rows, then decide.
// One word in flight; the next is taken the cycle after the result loads the output register;
// a result waits in the emit state while the output register still holds an unaccepted one.
// arst_n clears sequencer, queue pointers, table fill count, reuse_delay; last ID = RESERVED_LAST.
module delayed_recycle_id_allocator import dra_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	dra_req_if.sink     req,
	dra_rsp_if.source   rsp
);
	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
	localparam int CW     = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	state_t state_q, state_d;

	logic [31:0] delay_q;
	logic [31:0] last_q;
	logic [1:0]  op_q;
	logic [31:0] now_q;
	logic [31:0] target_q;

	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             cmp_vld_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             hit_dropped_q;
	logic [COUNT_BITS-1:0] hit_cnt_q;

	logic [31:0] res_id_q;
	logic [15:0] res_cnt_q;
	logic [1:0]  res_sts_q;

	logic        rsp_valid_q;
	logic [31:0] rsp_id_q;
	logic [15:0] rsp_cnt_q;
	logic [1:0]  rsp_sts_q;

	// table and queue hookup
	logic [IDX_W-1:0]      tbl_rd_addr;
	logic [31:0]           rd_id_q;
	logic                  rd_dropped_q;
	logic [31:0]           rd_time_q;
	logic [COUNT_BITS-1:0] rd_cnt_q;
	tbl_ctl_t              tbl_ctl;
	logic [IDX_W-1:0]      wr_addr;
	logic                  wr_dropped;
	logic [31:0]           wr_time;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic [USED_W-1:0]     used_q;
	logic                  tbl_full;
	fifo_ctl_t             fifo_ctl;
	logic [IDX_W-1:0]      push_idx;
	logic [IDX_W-1:0]      fifo_head_idx;
	logic                  fifo_empty;

	logic                  accept;
	logic                  emit_go;
	logic                  hit_now;
	logic                  aged;
	logic                  take_fresh;
	logic                  recycle;
	logic [31:0]           next_id;
	logic [31:0]           fresh_id;
	logic [COUNT_BITS-1:0] inc_cnt;

	function automatic logic [15:0] clamp16(input logic [COUNT_BITS-1:0] c);
		logic [CW-1:0] x;
		x = CW'(c);
		return (x > CW'(32'h0000_FFFF)) ? 16'hFFFF : x[15:0];
	endfunction

	dra_table #(
		.N     (TABLE_ENTRIES),
		.CB    (COUNT_BITS),
		.IDX_W (IDX_W),
		.USED_W(USED_W)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_addr     (tbl_rd_addr),
		.rd_id_q     (rd_id_q),
		.rd_dropped_q(rd_dropped_q),
		.rd_time_q   (rd_time_q),
		.rd_cnt_q    (rd_cnt_q),
		.ctl         (tbl_ctl),
		.wr_addr     (wr_addr),
		.wr_id       (target_q),
		.wr_dropped  (wr_dropped),
		.wr_time     (wr_time),
		.wr_cnt      (wr_cnt),
		.used_q      (used_q),
		.full        (tbl_full)
	);

	dra_fifo #(
		.DEPTH(TABLE_ENTRIES),
		.IDX_W(IDX_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (fifo_ctl),
		.push_idx  (push_idx),
		.head_idx_q(fifo_head_idx),
		.empty     (fifo_empty)
	);

	// Handshakes and shared arithmetic
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign emit_go   = !rsp_valid_q || rsp.ready;
	assign hit_now   = cmp_vld_s1 && (rd_id_q == target_q);
	assign aged      = (now_q - rd_time_q) > delay_q;
	assign next_id   = last_q + 32'd1;
	assign fresh_id  = (next_id == 32'd0) ? RESERVED_LAST + 32'd1 : next_id;
	assign inc_cnt   = (rd_cnt_q == '1) ? rd_cnt_q : rd_cnt_q + 1'b1;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_id   = rsp_id_q;
	assign rsp.reuse_count = rsp_cnt_q;
	assign rsp.status      = rsp_sts_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.opcode) inside
						OP_CREATE:         state_d = S_C_FIFO;
						OP_DROP, OP_QUERY: state_d = S_SCAN;
						default:           state_d = S_EMIT;
					endcase
				end
			end
			S_C_FIFO:   state_d = fifo_empty ? S_EMIT : S_C_TBL;
			S_C_TBL:    state_d = S_EMIT;
			S_SCAN: begin
				if (scan_q == IDX_W'(TABLE_ENTRIES - 1)) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: state_d = S_DECIDE;
			S_DECIDE:   state_d = S_EMIT;
			S_EMIT: begin
				if (emit_go) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: table and queue commands
	always_comb begin
		tbl_rd_addr = scan_q;
		tbl_ctl     = '0;
		wr_addr     = hit_idx_q;
		wr_dropped  = 1'b1;
		wr_time     = now_q;
		wr_cnt      = hit_cnt_q;
		fifo_ctl    = '0;
		push_idx    = hit_idx_q;
		take_fresh  = 1'b0;
		recycle     = 1'b0;
		unique case (state_q)
			S_C_FIFO: begin
				tbl_rd_addr = fifo_head_idx;
				take_fresh  = fifo_empty;
			end
			S_C_TBL: begin
				tbl_rd_addr = fifo_head_idx;
				if (aged) begin
					recycle         = 1'b1;
					tbl_ctl.attr_we = 1'b1;
					wr_addr         = fifo_head_idx;
					wr_dropped      = 1'b0;
					wr_time         = rd_time_q;
					wr_cnt          = inc_cnt;
					fifo_ctl.pop    = 1'b1;
				end else begin
					take_fresh = 1'b1;
				end
			end
			S_DECIDE: begin
				if (op_q == OP_DROP) begin
					if (hit_q) begin
						if (!hit_dropped_q) begin
							tbl_ctl.attr_we = 1'b1;
							fifo_ctl.push   = 1'b1;
						end
					end else if (!tbl_full) begin
						tbl_ctl.alloc   = 1'b1;
						tbl_ctl.attr_we = 1'b1;
						wr_addr         = used_q[IDX_W-1:0];
						wr_cnt          = '0;
						push_idx        = used_q[IDX_W-1:0];
						fifo_ctl.push   = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			delay_q     <= '0;
			last_q      <= RESERVED_LAST;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
			if (take_fresh) begin
				last_q <= fresh_id;
			end
			cmp_vld_s1 <= (state_q == S_SCAN) && (USED_W'(scan_q) < used_q);
			if (accept) begin
				hit_q <= 1'b0;
			end else if (hit_now) begin
				hit_q <= 1'b1;
			end
			if (state_q == S_EMIT && emit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture word, scan table, build result
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req.opcode;
			now_q     <= req.now_ticks;
			target_q  <= req.target_id;
			res_id_q  <= req.target_id;
			res_cnt_q <= '0;
			res_sts_q <= STS_OK;
		end
		scan_q     <= (state_q == S_SCAN) ? scan_q + 1'b1 : '0;
		cmp_idx_s1 <= scan_q;
		if (hit_now) begin
			hit_idx_q     <= cmp_idx_s1;
			hit_dropped_q <= rd_dropped_q;
			hit_cnt_q     <= rd_cnt_q;
		end
		if (take_fresh) begin
			res_id_q <= fresh_id;
		end
		if (recycle) begin
			res_id_q  <= rd_id_q;
			res_cnt_q <= clamp16(inc_cnt);
			res_sts_q <= STS_RECYCLED;
		end
		if (state_q == S_DECIDE) begin
			case (op_q)
				OP_DROP: begin
					if (hit_q && hit_dropped_q) begin
						res_sts_q <= STS_DUP;
					end else if (!hit_q && tbl_full) begin
						res_sts_q <= STS_FULL;
					end
				end
				OP_QUERY: begin
					if (hit_q) begin
						res_cnt_q <= clamp16(hit_cnt_q);
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_EMIT && emit_go) begin
			rsp_id_q  <= res_id_q;
			rsp_cnt_q <= res_cnt_q;
			rsp_sts_q <= res_sts_q;
		end
	end

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == S_EMIT))
		else $error("response raised outside emit state");

	a_check_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_C_TBL) |-> !fifo_empty)
		else $error("age check with empty quarantine queue");

	a_tbl_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_ctl.attr_we |-> (state_q == S_C_TBL || state_q == S_DECIDE))
		else $error("table written outside an update state");

	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		take_fresh |=> (last_q > RESERVED_LAST))
		else $error("fresh ID fell into the reserved range");

endmodule
